// File: sv/heightmap_triangle_height_query_defines.svh
// assertion macros for the height map query block
// used by the top level; relies on clk and rst in the including scope
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_DEFINES_SVH

// same-cycle implication
`define HMTQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HMTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hmtq_pkg.sv
// shared widths, register indexes, corner codes and controller/datapath structs
// no dependencies
package hmtq_pkg;

  localparam int DEFAULT_MAX_SIDE = 256;

  localparam int SIDE_W      = 9;
  localparam int SAMPLE_W    = 8;
  localparam int HEIGHT_W    = 16;
  localparam int POS_W       = 20;
  localparam int SPACING_W   = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_DEPTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_SPACING = 2'd2;

  localparam logic [SIDE_W-1:0]    GRID_SIDE_RESET   = 9'd256;
  localparam logic [SPACING_W-1:0] INV_SPACING_RESET = 16'd256;

  localparam logic OP_WRITE = 1'b0;

  // corner order: bit 1 steps the row, bit 0 steps the column
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;
  localparam logic [1:0] CORNER_D = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       chk;
    logic       issue;
    logic       issue_wr;
    logic [1:0] corner;
    logic       sel;
    logic       prod;
    logic       finish;
  } hmtq_cmd_t;

  typedef struct packed {
    logic ok;
    logic wr_done;
    logic rd_done;
    logic pipe_busy;
  } hmtq_sts_t;

endpackage

// File: sv/hmtq_ram.sv
// generic single-port ram with registered read
// no dependencies
module hmtq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/hmtq_ctrl.sv
// controller state machine: handshakes, query and write sequencing, output valid
// depends on hmtq_pkg
module hmtq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  output logic                out_valid,
  input  logic                out_stall,
  output hmtq_pkg::hmtq_cmd_t cmd,
  input  hmtq_pkg::hmtq_sts_t sts
);
  import hmtq_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_CHK      = 4'd2;
  localparam logic [3:0] S_ISSUE    = 4'd3;
  localparam logic [3:0] S_WAIT     = 4'd4;
  localparam logic [3:0] S_SEL      = 4'd5;
  localparam logic [3:0] S_PROD     = 4'd6;
  localparam logic [3:0] S_SUM      = 4'd7;
  localparam logic [3:0] S_WR_ISSUE = 4'd8;
  localparam logic [3:0] S_WR_WAIT  = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] corner, corner_next;
  logic       out_valid_next;
  logic       accept;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next  = state;
    corner_next = corner;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = (op == OP_WRITE) ? S_WR_ISSUE : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk     = 1'b1;
        corner_next = CORNER_A;
        state_next  = sts.ok ? S_ISSUE : S_SUM;
      end
      S_ISSUE: begin
        cmd.issue   = 1'b1;
        cmd.corner  = corner;
        corner_next = corner + 2'd1;
        if (corner == CORNER_D) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts.rd_done) begin
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        cmd.sel    = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WR_ISSUE: begin
        cmd.issue    = 1'b1;
        cmd.issue_wr = 1'b1;
        state_next   = S_WR_WAIT;
      end
      S_WR_WAIT: begin
        if (sts.wr_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.finish || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      corner    <= CORNER_A;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      corner    <= corner_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: sv/hmtq_datapath.sv
// datapath: config registers, cell mapping, address pipe with modulo, height ram,
// triangle interpolation and result register; depends on hmtq_pkg and hmtq_ram
module hmtq_datapath #(
  parameter int MAX_SIDE = hmtq_pkg::DEFAULT_MAX_SIDE
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [hmtq_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [hmtq_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [hmtq_pkg::SAMPLE_W-1:0]         sample_row,
  input  logic [hmtq_pkg::SAMPLE_W-1:0]         sample_col,
  input  logic signed [hmtq_pkg::HEIGHT_W-1:0]  sample_height,
  input  logic signed [hmtq_pkg::POS_W-1:0]     query_x,
  input  logic signed [hmtq_pkg::POS_W-1:0]     query_z,
  input  hmtq_pkg::hmtq_cmd_t                   cmd,
  output hmtq_pkg::hmtq_sts_t                   sts,
  output logic signed [hmtq_pkg::HEIGHT_W-1:0]  height,
  output logic                                  in_range
);
  import hmtq_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RAW_W = 19;
  localparam int MOD_W = (AW > RAW_W) ? AW : RAW_W;
  localparam logic [RAW_W:0] MOD_MUL = (RAW_W+1)'((1 << RAW_W) / DEPTH);
  localparam logic [MOD_W:0] DEPTH_C = (MOD_W+1)'(DEPTH);
  localparam logic [16:0]    ONE_Q16 = 17'h10000;

  // configuration
  logic [SIDE_W-1:0]    grid_width;
  logic [SIDE_W-1:0]    grid_depth;
  logic [SPACING_W-1:0] inv_spacing;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_SIDE_RESET;
      grid_depth  <= GRID_SIDE_RESET;
      inv_spacing <= INV_SPACING_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[SIDE_W-1:0];
        REG_GRID_DEPTH:  grid_depth  <= cfg_data[SIDE_W-1:0];
        REG_INV_SPACING: inv_spacing <= cfg_data[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture and cell mapping
  logic [SAMPLE_W-1:0]        row_smp, col_smp;
  logic [HEIGHT_W-1:0]        height_smp;
  logic signed [20:0]         px, pz;
  logic signed [37:0]         cq, dq;
  logic [20:0]                col_full, row_full, gw_lim, gd_lim;
  logic                       ok, ok_q;
  logic [8:0]                 col_cell, row_cell;
  logic [15:0]                s_frac, t_frac;

  assign col_full = cq[36:16];
  assign row_full = dq[36:16];
  assign gw_lim   = {12'b0, grid_width - 9'd2};
  assign gd_lim   = {12'b0, grid_depth - 9'd2};
  assign ok = (grid_width >= 9'd2) && (grid_depth >= 9'd2) && !cq[37] && !dq[37]
              && (col_full <= gw_lim) && (row_full <= gd_lim);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_smp    <= sample_row;
      col_smp    <= sample_col;
      height_smp <= sample_height;
      px <= $signed({query_x[POS_W-1], query_x}) + $signed({5'b0, grid_width, 7'b0});
      pz <= $signed({5'b0, grid_depth, 7'b0}) - $signed({query_z[POS_W-1], query_z});
    end
    if (cmd.mul) begin
      cq <= px * $signed({1'b0, inv_spacing});
      dq <= pz * $signed({1'b0, inv_spacing});
    end
    if (cmd.chk) begin
      ok_q     <= ok;
      col_cell <= cq[24:16];
      row_cell <= dq[24:16];
      s_frac   <= cq[15:0];
      t_frac   <= dq[15:0];
    end
  end

  // address pipe: row * width + col, then reduction modulo the store depth
  logic [9:0]         row_sel, col_sel;
  logic [RAW_W-1:0]   prod_rc, raw_next;
  logic               v1, v2, v3, v4;
  logic               wr1, wr2, wr3;
  logic [1:0]         tag1, tag2, tag3, tag4;
  logic [RAW_W-1:0]   raw1, raw2, q2;
  logic [2*RAW_W:0]   mod_prod;
  logic [MOD_W+RAW_W:0] qd;
  logic [MOD_W-1:0]   raw2_ext, r3, r_fix;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [HEIGHT_W-1:0] ram_rdata;

  assign row_sel  = cmd.issue_wr ? {2'b0, row_smp}
                                 : {1'b0, row_cell} + {9'b0, cmd.corner[1]};
  assign col_sel  = cmd.issue_wr ? {2'b0, col_smp}
                                 : {1'b0, col_cell} + {9'b0, cmd.corner[0]};
  assign prod_rc  = row_sel * grid_width;
  assign raw_next = prod_rc + {{(RAW_W-10){1'b0}}, col_sel};
  assign mod_prod = raw1 * MOD_MUL;
  assign qd       = q2 * DEPTH_C;
  assign raw2_ext = MOD_W'(raw2);
  assign r_fix    = ({1'b0, r3} >= DEPTH_C) ? r3 - DEPTH_C[MOD_W-1:0] : r3;
  assign ram_addr = r_fix[AW-1:0];
  assign ram_we   = v3 && wr3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3 && !wr3;
    end
  end

  always_ff @(posedge clk) begin
    raw1 <= raw_next;
    wr1  <= cmd.issue_wr;
    tag1 <= cmd.corner;
    raw2 <= raw1;
    q2   <= mod_prod[RAW_W +: RAW_W];
    wr2  <= wr1;
    tag2 <= tag1;
    r3   <= raw2_ext - qd[MOD_W-1:0];
    wr3  <= wr2;
    tag3 <= tag2;
    tag4 <= tag3;
  end

  hmtq_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (height_smp),
    .rdata (ram_rdata)
  );

  // corner capture
  logic [HEIGHT_W-1:0] a_h, b_h, c_h, d_h;

  always_ff @(posedge clk) begin
    if (v4) begin
      unique case (tag4)
        CORNER_A: a_h <= ram_rdata;
        CORNER_B: b_h <= ram_rdata;
        CORNER_C: c_h <= ram_rdata;
        CORNER_D: d_h <= ram_rdata;
      endcase
    end
  end

  assign sts.ok        = ok;
  assign sts.wr_done   = v3 && wr3;
  assign sts.rd_done   = v4 && (tag4 == CORNER_D);
  assign sts.pipe_busy = v1 || v2 || v3 || v4;

  // triangle interpolation
  logic signed [16:0] a_x, b_x, c_x, d_x;
  logic               upper;
  logic [HEIGHT_W-1:0] base;
  logic [16:0]        f1, f2;
  logic signed [16:0] d1, d2;
  logic signed [34:0] p1, p2;
  logic signed [35:0] base_x, acc;
  logic signed [19:0] hq;
  logic [HEIGHT_W-1:0] sat;

  assign a_x   = {a_h[15], a_h};
  assign b_x   = {b_h[15], b_h};
  assign c_x   = {c_h[15], c_h};
  assign d_x   = {d_h[15], d_h};
  assign upper = ({1'b0, s_frac} + {1'b0, t_frac}) <= ONE_Q16;

  assign base_x = {{4{base[15]}}, base, 16'h0000};
  assign acc    = base_x + p1 + p2 + 36'sd32768;
  assign hq     = acc[35:16];

  always_comb begin
    if (hq > 20'sd32767) begin
      sat = 16'h7FFF;
    end else if (hq < -20'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = hq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      if (upper) begin
        base <= a_h;
        f1   <= {1'b0, s_frac};
        d1   <= b_x - a_x;
        f2   <= {1'b0, t_frac};
        d2   <= c_x - a_x;
      end else begin
        base <= d_h;
        f1   <= ONE_Q16 - {1'b0, s_frac};
        d1   <= c_x - d_x;
        f2   <= ONE_Q16 - {1'b0, t_frac};
        d2   <= b_x - d_x;
      end
    end
    if (cmd.prod) begin
      p1 <= $signed({1'b0, f1}) * d1;
      p2 <= $signed({1'b0, f2}) * d2;
    end
    if (cmd.finish) begin
      height   <= ok_q ? sat : '0;
      in_range <= ok_q;
    end
  end

endmodule

// File: sv/heightmap_triangle_height_query.sv
// top level of the height map query block: controller, datapath, assertions
// depends on hmtq_pkg, hmtq_ctrl, hmtq_datapath and the defines header
//
// Usage:
//   Input channel (in_valid / in_stall): op 0 writes sample_height at
//   (sample_row, sample_col); op 1 queries the height at (query_x, query_z).
//   Output channel (out_valid / out_stall): one result per query, none per
//   write; height is 0 and in_range is 0 outside the last full cell.
//   Configuration: cfg_write with cfg_index and cfg_data, only while idle.
//   One request at a time; the next request can be taken in the cycle in
//   which out_valid first shows the result. The four corner reads of a query
//   in range share the single ram port and pass a four-stage address and
//   modulo pipe. An out-of-range query skips the corner reads, and a write
//   sends one address through the pipe and returns no result.
//   A finished result sits in the output register while the next request is
//   accepted; if out_stall holds it, the following query waits at its last
//   step and in_stall stays high until the register frees.
//   Reset clears the control state and sets the three registers to 256.
//   The height ram has no reset; entries read before written are undefined.
`include "heightmap_triangle_height_query_defines.svh"

module heightmap_triangle_height_query #(
  parameter int MAX_SIDE = hmtq_pkg::DEFAULT_MAX_SIDE
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [hmtq_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [hmtq_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  op,
  input  logic [hmtq_pkg::SAMPLE_W-1:0]         sample_row,
  input  logic [hmtq_pkg::SAMPLE_W-1:0]         sample_col,
  input  logic signed [hmtq_pkg::HEIGHT_W-1:0]  sample_height,
  input  logic signed [hmtq_pkg::POS_W-1:0]     query_x,
  input  logic signed [hmtq_pkg::POS_W-1:0]     query_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [hmtq_pkg::HEIGHT_W-1:0]  height,
  output logic                                  in_range
);
  import hmtq_pkg::*;

  hmtq_cmd_t cmd;
  hmtq_sts_t sts;

  hmtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  hmtq_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_row    (sample_row),
    .sample_col    (sample_col),
    .sample_height (sample_height),
    .query_x       (query_x),
    .query_z       (query_z),
    .cmd           (cmd),
    .sts           (sts),
    .height        (height),
    .in_range      (in_range)
  );

  `HMTQ_ASSERT_NOW(a_accept_pipe_empty, in_valid && !in_stall, !sts.pipe_busy, "request taken with address pipe busy")
  `HMTQ_ASSERT_NOW(a_finish_free, cmd.finish, !out_valid || !out_stall, "result overwrote a pending result")
  `HMTQ_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid, "finished result not presented")
  `HMTQ_ASSERT_NOW(a_out_of_range_zero, out_valid && !in_range, height == 16'sd0, "out of range result not zero")

endmodule
